// File: src/svt_pkg.sv
// Shared types and constants for the sorted value table.
// Used by sorted_value_table; depends on nothing else.
package svt_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned OpWidth    = 2;
   localparam int unsigned CountOut   = 5;

   typedef enum logic [OpWidth-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_INS  = 6'b000010,
      ST_PUT  = 6'b000100,
      ST_SRCH = 6'b001000,
      ST_DEL  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

endpackage

// File: src/sorted_value_table.sv
// Sorted multiset of signed values held in one synchronous memory.
// Depends on svt_pkg; checked by svt_check (bound in svt_check.sv).
//
// Channel | Dir | Bits of tdata
// req     | in  | [1:0] operation, [33:2] value, [39:34] zero
// rsp     | out | [0] success, [5:1] entry_count, [7:6] zero
//
// One request at a time. An insert moves each entry above the new value up
// by one; a delete or lookup scans from index zero to the match or first
// larger entry, and a delete then moves the followers down by one. The
// single read and single write port set the pace: one entry per cycle.
// Reset (synchronous) empties the table; memory contents are not cleared.
// A response waiting on rsp_tready holds the next result in the sequencer.
module sorted_value_table #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // operation, value, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // success, entry_count, zero fill
);
   import svt_pkg::*;

   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic signed [ValueWidth-1:0] mem [CAPACITY];
   logic signed [ValueWidth-1:0] rd_data_ff;
   logic                         rd_en;
   logic [IW-1:0]                rd_addr;
   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic signed [ValueWidth-1:0] wr_data;

   state_type                    state_ff, state_in;
   op_type                       op_ff, op_in;
   logic signed [ValueWidth-1:0] key_ff, key_in;
   logic [IW-1:0]                ptr_ff, ptr_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         ok_ff, ok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [CountOut-1:0]          rsp_cnt_ff, rsp_cnt_in;

   logic [CW-1:0]                cnt_dec;
   logic [IW-1:0]                last_idx;
   logic                         at_last;
   logic [CW+CountOut-1:0]       cnt_wide;

   assign cnt_dec  = cnt_ff - CW'(1);
   assign last_idx = cnt_dec[IW-1:0];
   assign at_last  = (ptr_ff == last_idx);
   assign cnt_wide = {{CountOut{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = key_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tdata[1:0]);
               key_in   = $signed(req_tdata[33:2]);
               ok_in    = 1'b0;
               state_in = ST_FIN;
               case (op_type'(req_tdata[1:0]))
                  OP_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        state_in = ST_FIN;
                     end else if (cnt_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        ptr_in   = last_idx;
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        state_in = ST_INS;
                     end
                  end
                  OP_DELETE, OP_LOOKUP: begin
                     if (cnt_ff != '0) begin
                        ptr_in   = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SRCH;
                     end
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_INS: begin
            // Walk down from the top, moving each larger entry up by one.
            wr_en   = 1'b1;
            wr_addr = ptr_ff + IW'(1);
            if (rd_data_ff > key_ff) begin
               wr_data = rd_data_ff;
               if (ptr_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  ptr_in  = ptr_ff - IW'(1);
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - IW'(1);
               end
            end else begin
               wr_data  = key_ff;
               cnt_in   = cnt_ff + CW'(1);
               ok_in    = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            cnt_in   = cnt_ff + CW'(1);
            ok_in    = 1'b1;
            state_in = ST_FIN;
         end
         ST_SRCH: begin
            // Entries are ascending, so the first larger one ends the search.
            if (rd_data_ff == key_ff) begin
               ok_in = 1'b1;
               if (op_ff == OP_LOOKUP) begin
                  state_in = ST_FIN;
               end else if (at_last) begin
                  cnt_in   = cnt_dec;
                  state_in = ST_FIN;
               end else begin
                  ptr_in   = ptr_ff + IW'(1);
                  rd_en    = 1'b1;
                  rd_addr  = ptr_ff + IW'(1);
                  state_in = ST_DEL;
               end
            end else if (rd_data_ff > key_ff || at_last) begin
               state_in = ST_FIN;
            end else begin
               ptr_in  = ptr_ff + IW'(1);
               rd_en   = 1'b1;
               rd_addr = ptr_ff + IW'(1);
            end
         end
         ST_DEL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - IW'(1);
            wr_data = rd_data_ff;
            if (at_last) begin
               cnt_in   = cnt_dec;
               state_in = ST_FIN;
            end else begin
               ptr_in  = ptr_ff + IW'(1);
               rd_en   = 1'b1;
               rd_addr = ptr_ff + IW'(1);
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_cnt_in   = cnt_wide[CountOut-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      ptr_ff     <= ptr_in;
      ok_ff      <= ok_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_cnt_ff, rsp_ok_ff};

endmodule

// File: src/svt_check.sv
// Port-level checker for sorted_value_table, attached by the bind below.
// Depends on the top level's ports only.
module svt_check #(
   parameter int unsigned CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // The table works on one request at a time.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous transaction was in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY >= 32 || int'(rsp_tdata[5:1]) <= CAPACITY))
      else $error("entry count above capacity");

   // A response never appears without a request having been taken first.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response raised while the table was idle");

endmodule

bind sorted_value_table svt_check #(.CAPACITY(CAPACITY)) u_svt_check (.*);
